// File: sv/websocket_frame_receiver_macros.svh
// assertion macros used by the websocket frame receiver rtl
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define WSFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define WSFR_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WSFR_ASSERT(label, clk, rst, prop, msg)
`define WSFR_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: sv/wsfr_pkg.sv
// types and constants of the websocket frame receiver
`timescale 1ns / 1ps
`default_nettype none
package wsfr_pkg;

  localparam int KEY_BYTES = 4;
  localparam int KEY_IDX_W = $clog2(KEY_BYTES);
  localparam int LEN_W     = 64;

  // opcodes of the low nibble of the first header byte
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // seven-bit length codes that announce an extended length
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LEN     = 3'd1,
    PH_EXLEN   = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TEXT = 3'd0,
    KIND_BIN  = 3'd1,
    KIND_PING = 3'd2,
    KIND_PONG = 3'd3
  } kind_t;

  typedef enum logic [1:0] {
    PREV_NONE = 2'd0,
    PREV_TEXT = 2'd1,
    PREV_BIN  = 2'd2
  } prev_t;

  typedef enum logic [3:0] {
    EV_TEXT       = 4'd0,
    EV_BIN        = 4'd1,
    EV_PONG_BYTE  = 4'd2,
    EV_PONG_EMPTY = 4'd3,
    EV_CLOSE      = 4'd4,
    EV_BAD_OPCODE = 4'd5,
    EV_UNMASKED   = 4'd6,
    EV_PING_BIG   = 4'd7,
    EV_NO_PRIOR   = 4'd8
  } ev_t;

  // one result request as it sits in the queue
  typedef struct packed {
    ev_t        code;
    logic [7:0] data;
    logic       last;
  } q_entry_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: sv/wsfr_if.sv
// handshake interfaces for the byte input and the event output
`timescale 1ns / 1ps
`default_nettype none
interface wsfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfr_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_code;
  logic [7:0] payload_byte;
  logic       frame_last;
  modport source (output valid, output event_code, output payload_byte,
                  output frame_last, input ready);
  modport sink (input valid, input event_code, input payload_byte,
                input frame_last, output ready);
endinterface
`default_nettype wire

// File: sv/wsfr_front.sv
// header parser and unmasker: accepts bytes and queues result requests
`timescale 1ns / 1ps
`default_nettype none
module wsfr_front
  import wsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  wsfr_byte_if.sink     rx,
  input  wire logic [23:0] ping_size_limit,
  input  wire q_stat_t  stat,
  output logic          push,
  output q_entry_t      entry
);

  phase_t                phase, phase_next;
  kind_t                 kind, kind_next;
  prev_t                 prev_kind, prev_kind_next;
  logic [LEN_W-1:0]      remaining, remaining_next;
  logic [3:0]            len_left, len_left_next;
  logic [KEY_IDX_W-1:0]  key_idx, key_idx_next;
  logic [KEY_IDX_W-1:0]  pos, pos_next;
  logic                  halted, halted_next;
  logic [7:0]            mask_key [KEY_BYTES];
  logic                  key_we;

  logic                  accept;
  logic [7:0]            b;
  logic [LEN_W-1:0]      shifted_len;
  logic                  over_limit;

  assign rx.ready = !stat.full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;

  // extended length after this byte and its check against the ping limit
  assign shifted_len = {remaining[LEN_W-9:0], b};
  assign over_limit  = (shifted_len[LEN_W-1:24] != '0) ||
                       (shifted_len[23:0] > ping_size_limit);

  // parser next state and result request
  always_comb begin
    phase_next     = phase;
    kind_next      = kind;
    prev_kind_next = prev_kind;
    remaining_next = remaining;
    len_left_next  = len_left;
    key_idx_next   = key_idx;
    pos_next       = pos;
    halted_next    = halted;
    key_we         = 1'b0;
    push           = 1'b0;
    entry.code     = EV_TEXT;
    entry.data     = 8'h00;
    entry.last     = 1'b0;
    if (accept && !halted) begin
      unique case (phase)
        PH_OPCODE: begin
          phase_next = PH_LEN;
          unique case (b[3:0])
            OP_CONT: begin
              if (prev_kind == PREV_TEXT) begin
                kind_next = KIND_TEXT;
              end else if (prev_kind == PREV_BIN) begin
                kind_next = KIND_BIN;
              end else begin
                halted_next = 1'b1;
                push        = 1'b1;
                entry.code  = EV_NO_PRIOR;
              end
            end
            OP_TEXT: begin
              kind_next      = KIND_TEXT;
              prev_kind_next = PREV_TEXT;
            end
            OP_BINARY: begin
              kind_next      = KIND_BIN;
              prev_kind_next = PREV_BIN;
            end
            OP_PING: kind_next = KIND_PING;
            OP_PONG: kind_next = KIND_PONG;
            OP_CLOSE: begin
              halted_next = 1'b1;
              push        = 1'b1;
              entry.code  = EV_CLOSE;
            end
            default: begin
              halted_next = 1'b1;
              push        = 1'b1;
              entry.code  = EV_BAD_OPCODE;
            end
          endcase
        end
        PH_LEN: begin
          if (!b[7]) begin
            halted_next = 1'b1;
            push        = 1'b1;
            entry.code  = EV_UNMASKED;
          end else begin
            key_idx_next = '0;
            if (b[6:0] == LEN7_EXT16) begin
              remaining_next = '0;
              len_left_next  = EXT16_BYTES;
              phase_next     = PH_EXLEN;
            end else if (b[6:0] == LEN7_EXT64) begin
              remaining_next = '0;
              len_left_next  = EXT64_BYTES;
              phase_next     = PH_EXLEN;
            end else begin
              remaining_next = {{(LEN_W-7){1'b0}}, b[6:0]};
              phase_next     = PH_KEY;
            end
          end
        end
        PH_EXLEN: begin
          remaining_next = shifted_len;
          len_left_next  = len_left - 4'd1;
          if (len_left == 4'd1) begin
            if (kind == KIND_PING && over_limit) begin
              halted_next = 1'b1;
              push        = 1'b1;
              entry.code  = EV_PING_BIG;
            end else begin
              phase_next = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          key_we = 1'b1;
          if (key_idx == KEY_IDX_W'(KEY_BYTES - 1)) begin
            key_idx_next = '0;
            pos_next     = '0;
            if (remaining == '0) begin
              phase_next = PH_OPCODE;
              if (kind == KIND_PING) begin
                push       = 1'b1;
                entry.code = EV_PONG_EMPTY;
                entry.last = 1'b1;
              end
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end else begin
            key_idx_next = key_idx + 1'b1;
          end
        end
        PH_PAYLOAD: begin
          pos_next       = pos + 1'b1;
          remaining_next = remaining - 1'b1;
          entry.data     = b ^ mask_key[pos];
          entry.last     = (remaining == {{(LEN_W-1){1'b0}}, 1'b1});
          if (entry.last) begin
            phase_next = PH_OPCODE;
          end
          unique case (kind)
            KIND_TEXT: begin
              push       = 1'b1;
              entry.code = EV_TEXT;
            end
            KIND_BIN: begin
              push       = 1'b1;
              entry.code = EV_BIN;
            end
            KIND_PING: begin
              push       = 1'b1;
              entry.code = EV_PONG_BYTE;
            end
            default: push = 1'b0;
          endcase
        end
        default: phase_next = PH_OPCODE;
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      kind      <= KIND_TEXT;
      prev_kind <= PREV_NONE;
      remaining <= '0;
      len_left  <= '0;
      key_idx   <= '0;
      pos       <= '0;
      halted    <= 1'b0;
    end else begin
      phase     <= phase_next;
      kind      <= kind_next;
      prev_kind <= prev_kind_next;
      remaining <= remaining_next;
      len_left  <= len_left_next;
      key_idx   <= key_idx_next;
      pos       <= pos_next;
      halted    <= halted_next;
    end
  end

  // masking key bytes, written during the key phase
  always_ff @(posedge clk) begin
    if (key_we) begin
      mask_key[key_idx] <= b;
    end
  end

endmodule
`default_nettype wire

// File: sv/wsfr_fifo.sv
// short request queue between the parser and the output stage
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_receiver_macros.svh"
module wsfr_fifo
  import wsfr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire q_entry_t push_entry,
  input  wire logic     pop,
  output q_entry_t      head,
  output q_stat_t       stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign head       = mem[rd_ptr];

  // storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue checks
  `WSFR_ASSERT_NEVER(a_no_overflow, clk, rst, push && stat.full, "queue overflow")
  `WSFR_ASSERT_NEVER(a_no_underflow, clk, rst, pop && stat.empty, "queue underflow")
  `WSFR_ASSERT(a_push_fills, clk, rst, (push && !pop) |=> !stat.empty, "push lost")

endmodule
`default_nettype wire

// File: sv/wsfr_back.sv
// output stage: drains the queue into a registered event channel
`timescale 1ns / 1ps
`default_nettype none
module wsfr_back
  import wsfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_entry_t head,
  input  wire q_stat_t  stat,
  output logic          pop,
  wsfr_event_if.source  events
);

  logic     out_valid;
  q_entry_t out_entry;

  // take the next request whenever the output register frees up
  assign pop = !stat.empty && (!out_valid || events.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_entry <= head;
    end
  end

  assign events.valid        = out_valid;
  assign events.event_code   = 4'(out_entry.code);
  assign events.payload_byte = out_entry.data;
  assign events.frame_last   = out_entry.last;

endmodule
`default_nettype wire

// File: sv/websocket_frame_receiver.sv
// top level of the websocket frame receiver
//
//   channel  dir  payload                                  request moves
//   rx       in   rx_byte[7:0]                             one stream byte
//   events   out  event_code[3:0] payload_byte frame_last  one event
//   cfg      in   cfg_wr_en, cfg_wr_data[23:0]             ping size limit
//
// one byte per clock is accepted while the request queue has room; a result
// is registered into the queue by the parser, then into the output register.
// the parser does its header and unmask work on each byte as it is accepted.
// rx.ready drops only while the request queue is full.
// synchronous reset clears parser state, queue and output valid; the limit
// returns to 65535. after a halting event bytes are taken and dropped.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_receiver
  import wsfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  wsfr_byte_if.sink        rx,
  wsfr_event_if.source     events,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data
);

  localparam logic [23:0] PING_LIMIT_RESET = 24'd65535;

  logic [23:0] ping_size_limit;
  logic        push;
  logic        pop;
  q_entry_t    push_entry;
  q_entry_t    head;
  q_stat_t     stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ping_size_limit <= PING_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      ping_size_limit <= cfg_wr_data;
    end
  end

  wsfr_front u_front (
    .clk             (clk),
    .rst             (rst),
    .rx              (rx),
    .ping_size_limit (ping_size_limit),
    .stat            (stat),
    .push            (push),
    .entry           (push_entry)
  );

  wsfr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (stat)
  );

  wsfr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .stat   (stat),
    .pop    (pop),
    .events (events)
  );

endmodule
`default_nettype wire
